// ===== hdl/hld_pkg.sv =====
// package for the hex line draw core: widths, fixed-point constants, helpers
// no dependencies
package hld_pkg;

    localparam int FRAC_BITS = 24;
    localparam int NUDGE_QR  = 17;
    localparam int NUDGE_S   = 34;
    localparam int DEF_COORD_LIMIT = 15;
    // working width of fractional coordinates: sign, up to 8 integer bits, 24 fraction
    localparam int FXW = 33;

    typedef logic signed [FXW-1:0] fx_t;

    // round half away from zero of a Q.24 value, integer result
    function automatic logic signed [8:0] round_half(input fx_t x);
        logic [FXW-1:0] mag;
        logic [FXW-1:0] sum;
        begin
            mag = x[FXW-1] ? FXW'(-x) : FXW'(x);
            sum = mag + FXW'(1 << (FRAC_BITS - 1));
            round_half = x[FXW-1] ? -$signed({1'b0, sum[FRAC_BITS+7:FRAC_BITS]})
                                  :  $signed({1'b0, sum[FRAC_BITS+7:FRAC_BITS]});
        end
    endfunction

    // rounding error magnitude, Q.24
    function automatic logic [FRAC_BITS:0] round_err(input logic signed [8:0] r, input fx_t x);
        fx_t d;
        begin
            d = fx_t'({r, {FRAC_BITS{1'b0}}}) - x;
            round_err = d[FXW-1] ? (FRAC_BITS+1)'(-d) : (FRAC_BITS+1)'(d);
        end
    endfunction

endpackage

// ===== hdl/hld_div.sv =====
// restoring divider for t = floor(i * 2^24 / n), one quotient bit per stage
// depends on hld_pkg
module hld_div #(
    parameter int NW = 6
) (
    input  logic clk,
    input  logic en,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic [hld_pkg::FRAC_BITS:0] quo
);
    import hld_pkg::*;
    localparam int QW  = FRAC_BITS + 1;
    localparam int STG = QW;   // one quotient bit per stage

    // remainder, quotient bits and divisor travel down the pipe together
    logic [NW:0]    rem_reg [1:STG-1];
    logic [QW-1:0]  q_reg   [1:STG];
    logic [NW-1:0]  d_reg   [1:STG-1];

    genvar g;
    generate
        for (g = 0; g < STG; g++)
        begin : g_stage
            logic [NW:0]   rem_cur;
            logic [QW-1:0] q_cur;
            logic [NW-1:0] d_cur;
            logic          dvd_bit;
            logic [NW+1:0] shf;
            logic [NW:0]   trial;
            logic          take;

            // i <= n, so the leading NW-1 dividend bits give no quotient bit;
            // the rest of the dividend is i[0] followed by zeros
            if (g == 0)
            begin : g_first
                assign rem_cur = (NW+1)'(num >> 1);
                assign q_cur   = '0;
                assign d_cur   = den;
                assign dvd_bit = num[0];
            end
            else
            begin : g_next
                assign rem_cur = rem_reg[g];
                assign q_cur   = q_reg[g];
                assign d_cur   = d_reg[g];
                assign dvd_bit = 1'b0;
            end

            // trial subtraction
            assign shf   = {rem_cur, dvd_bit};
            assign take  = (shf >= {2'b0, d_cur});
            assign trial = (NW+1)'(shf - {2'b0, d_cur});

            always_ff @(posedge clk)
            begin
                if (en)
                    q_reg[g+1] <= {q_cur[QW-2:0], take};
            end

            // remainder and divisor are needed only by later stages
            if (g < STG - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[g+1] <= take ? trial : shf[NW:0];
                        d_reg[g+1]   <= d_cur;
                    end
                end
            end
        end
    endgenerate

    assign quo = q_reg[STG];
endmodule

// ===== hdl/hex_line_draw_core.sv =====
// top level of the hex line draw core: sequencer, divider pipe, interpolate and round stages
// depends on hld_pkg and hld_div
//
// Takes a start and end hex in cube coordinates and emits the N+1 hexes on the line
// between them, one per cycle while out_stall is low, start first, the last flagged by
// last_hex. N is the cube distance, capped at 4*COORD_LIMIT. An input item holds the
// sequencer until its last hex has been stepped out, and in_stall stays high for that
// time, so the next item is taken only once the sequencer is idle again. Results leave
// a pipeline of 28 register stages (25 for the quotient bits of t = i*2^24/N, then
// interpolation, rounding and the output register). A stalled result at the output
// freezes the whole pipeline, sequencer included, so each stalled cycle lengthens the
// item.
module hex_line_draw_core #(
    parameter int COORD_LIMIT = hld_pkg::DEF_COORD_LIMIT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [4:0] from_q,
    input  logic signed [4:0] from_r,
    input  logic signed [5:0] from_s,
    input  logic signed [4:0] to_q,
    input  logic signed [4:0] to_r,
    input  logic signed [5:0] to_s,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [4:0] hex_q,
    output logic signed [4:0] hex_r,
    output logic signed [5:0] hex_s,
    output logic [5:0] step_index,
    output logic last_hex
);
    import hld_pkg::*;
    localparam int MAX_STEPS = 4 * COORD_LIMIT;
    localparam int DIV_STG = FRAC_BITS + 1;
    localparam int LAT = DIV_STG;

    logic adv;
    assign adv = !(out_valid && out_stall);

    // input item register and step counter
    logic busy_reg;
    logic signed [5:0] fq_reg, fr_reg, fs_reg;
    logic signed [6:0] dq_reg, dr_reg, ds_reg;
    logic [5:0] n_reg, i_reg;
    logic signed [6:0] dq_in, dr_in, ds_in;
    logic [7:0] dist_sum;
    logic [5:0] n_in;

    always_comb
    begin
        dq_in = 7'(to_q) - 7'(from_q);
        dr_in = 7'(to_r) - 7'(from_r);
        ds_in = 7'(to_s) - 7'(from_s);
        dist_sum = 8'(dq_in[6] ? -dq_in : dq_in) + 8'(dr_in[6] ? -dr_in : dr_in)
                 + 8'(ds_in[6] ? -ds_in : ds_in);
        n_in = (dist_sum[7:1] > 7'(MAX_STEPS)) ? 6'(MAX_STEPS) : dist_sum[6:1];
    end

    assign in_stall = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
        end
        else if (adv)
        begin
            if (i_reg == n_reg)
                busy_reg <= 1'b0;
            i_reg <= i_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && in_valid)
        begin
            fq_reg <= 6'(from_q);
            fr_reg <= 6'(from_r);
            fs_reg <= from_s;
            dq_reg <= dq_in;
            dr_reg <= dr_in;
            ds_reg <= ds_in;
            n_reg  <= n_in;
        end
    end

    // divider pipe; sideband travels alongside
    logic [FRAC_BITS:0] t_quo;
    hld_div #(.NW(6)) u_div (
        .clk(clk), .en(adv),
        .num(i_reg), .den((n_reg == 6'd0) ? 6'd1 : n_reg), .quo(t_quo)
    );

    typedef struct packed {
        logic valid;
        logic last;
        logic [5:0] idx;
        logic zero;
        logic signed [5:0] fq, fr, fs;
        logic signed [6:0] dq, dr, ds;
    } side_t;

    side_t sb_in;
    side_t sb_reg [1:LAT];
    always_comb
    begin
        sb_in.valid = busy_reg;
        sb_in.last  = (i_reg == n_reg);
        sb_in.idx   = i_reg;
        sb_in.zero  = (n_reg == 6'd0);
        sb_in.fq = fq_reg; sb_in.fr = fr_reg; sb_in.fs = fs_reg;
        sb_in.dq = dq_reg; sb_in.dr = dr_reg; sb_in.ds = ds_reg;
    end

    // sideband pipe, in step with the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
                sb_reg[k] <= '0;
        end
        else if (adv)
        begin
            sb_reg[1] <= sb_in;
            for (int k = 2; k <= LAT; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // sideband of the interpolation and rounding stages
    side_t s1_reg, s2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= sb_reg[LAT];
            s2_reg <= s1_reg;
        end
    end

    // interpolation stage: p = a + d*t
    fx_t pq_reg, pr_reg, ps_reg;
    logic [FRAC_BITS:0] t_eff;
    logic signed [FRAC_BITS+1:0] t_s;
    fx_t mq, mr, ms;
    assign t_eff = sb_reg[LAT].zero ? '0 : t_quo;

    always_comb
    begin
        t_s = $signed({1'b0, t_eff});
        mq  = sb_reg[LAT].dq * t_s;
        mr  = sb_reg[LAT].dr * t_s;
        ms  = sb_reg[LAT].ds * t_s;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pq_reg <= fx_t'($signed({sb_reg[LAT].fq, {FRAC_BITS{1'b0}}})) + FXW'(NUDGE_QR)
                    + mq;
            pr_reg <= fx_t'($signed({sb_reg[LAT].fr, {FRAC_BITS{1'b0}}})) + FXW'(NUDGE_QR)
                    + mr;
            ps_reg <= fx_t'($signed({sb_reg[LAT].fs, {FRAC_BITS{1'b0}}})) - FXW'(NUDGE_S)
                    + ms;
        end
    end

    // rounding stage
    logic signed [8:0] rq_reg, rr_reg, rs_reg;
    logic [FRAC_BITS:0] eq_reg, er_reg, es_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rq_reg <= round_half(pq_reg);
            rr_reg <= round_half(pr_reg);
            rs_reg <= round_half(ps_reg);
            eq_reg <= round_err(round_half(pq_reg), pq_reg);
            er_reg <= round_err(round_half(pr_reg), pr_reg);
            es_reg <= round_err(round_half(ps_reg), ps_reg);
        end
    end

    // fixup of the worst coordinate, then output register
    logic out_valid_reg;
    logic signed [8:0] oq, orr, os;
    always_comb
    begin
        oq = rq_reg; orr = rr_reg; os = rs_reg;
        if (eq_reg > er_reg && eq_reg > es_reg)
            oq = -rr_reg - rs_reg;
        else if (er_reg > es_reg)
            orr = -rq_reg - rs_reg;
        else
            os = -rq_reg - rr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hex_q      <= oq[4:0];
            hex_r      <= orr[4:0];
            hex_s      <= os[5:0];
            step_index <= s2_reg.idx;
            last_hex   <= s2_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
